@@ rtl/min_heap_priority_queue_assert.svh @@
// Assertion helpers for the heap RTL.
// Each macro expects i_clk and i_rst_n in scope.
`ifndef MIN_HEAP_PRIORITY_QUEUE_ASSERT_SVH
`define MIN_HEAP_PRIORITY_QUEUE_ASSERT_SVH

// Same-cycle implication.
`define MHPQ_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define MHPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/mhpq_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package mhpq_pkg;

    localparam int DATA_W = 32;

    localparam logic [2:0] CMD_INSERT = 3'd0;
    localparam logic [2:0] CMD_REMOVE = 3'd1;
    localparam logic [2:0] CMD_PEEK   = 3'd2;
    localparam logic [2:0] CMD_SEARCH = 3'd3;
    localparam logic [2:0] CMD_MAX    = 3'd4;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_EMPTY    = 2'd2;
    localparam logic [1:0] ST_NOTFOUND = 2'd3;

    localparam logic signed [DATA_W-1:0] DATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    typedef struct packed {
        logic lt;
        logic eq;
        logic gt;
    } t_cmp_flags;

endpackage

`default_nettype wire

@@ rtl/min_heap_priority_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Bounded binary min-heap of signed 32-bit values, CAPACITY entries.
// Command channel: drive i_command and i_value with start high; the transaction
// is taken on a rising edge where start is high and busy is low. busy stays
// high until the result has been issued.
// Result channel: o_done pulses for one cycle with o_status, o_result_value
// and o_entry_count; the receiver has no way to stall it and must take it then.
// Work per command, n entries held before:
//   insert       climbs from the new leaf, moving each larger parent down,
//                and writes the value where the climb stops
//   remove-min   reads the root, then the last entry, then walks down: at each
//                node reads the left child, then the right child if present,
//                and moves the smaller child up while it is below the last entry
//   peek-min     reads the root
//   search, max  read all n entries (one entry read per cycle)
//   full/empty and unused commands: answered straight from idle
// The steps follow from the single RAM read port (registered data) and the
// one shared comparator, each used at most once per step of the sequencer.
// One command at a time; the next may be given in the cycle o_done is high.
// Reset (synchronous, active low) empties the heap; stored entries are not
// cleared, since only entries below the fill count are ever read.
module min_heap_priority_queue #(
    parameter int CAPACITY = 16
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                start,
    output logic                                     busy,
    input  wire logic [2:0]                          i_command,
    input  wire logic signed [mhpq_pkg::DATA_W-1:0]  i_value,
    output logic                                     o_done,
    output logic [1:0]                               o_status,
    output logic signed [mhpq_pkg::DATA_W-1:0]       o_result_value,
    output logic [4:0]                               o_entry_count
);

    import mhpq_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = AW + 2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_UP_RD,
        S_UP_CMP,
        S_RM_ROOT,
        S_RM_LAST,
        S_DN_L,
        S_DN_R,
        S_DN_C,
        S_DN_D,
        S_PEEK,
        S_SCAN
    } t_state;

    t_state                    r_state, n_state;
    logic [2:0]                r_cmd, n_cmd;
    logic signed [DATA_W-1:0]  r_val, n_val;
    logic [CW-1:0]             r_cnt, n_cnt;
    logic [AW-1:0]             r_pos, n_pos;
    logic signed [DATA_W-1:0]  r_cur, n_cur;
    logic signed [DATA_W-1:0]  r_res, n_res;
    logic signed [DATA_W-1:0]  r_best, n_best;
    logic [AW-1:0]             r_best_idx, n_best_idx;
    logic [CW-1:0]             r_idx, n_idx;
    logic                      r_pend, n_pend;
    logic                      r_hit, n_hit;

    logic                      fin;
    logic [1:0]                fin_status;
    logic signed [DATA_W-1:0]  fin_value;

    logic                      ram_we;
    logic [AW-1:0]             ram_waddr;
    logic signed [DATA_W-1:0]  ram_wdata;
    logic [AW-1:0]             ram_raddr;
    logic signed [DATA_W-1:0]  ram_rdata;

    logic signed [DATA_W-1:0]  cmp_a;
    logic signed [DATA_W-1:0]  cmp_b;
    t_cmp_flags                cmp;

    logic [IW-1:0]             w_lc;
    logic [IW-1:0]             w_rc;
    logic [IW-1:0]             w_cnt_x;
    logic [AW-1:0]             w_parent;

    mhpq_ram #(
        .WIDTH (DATA_W),
        .DEPTH (CAPACITY)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    mhpq_cmp u_cmp (
        .i_a     (cmp_a),
        .i_b     (cmp_b),
        .o_flags (cmp)
    );

    assign busy     = (r_state != S_IDLE);
    assign w_lc     = (IW'(r_pos) << 1) + IW'(1);
    assign w_rc     = w_lc + IW'(1);
    assign w_cnt_x  = IW'(r_cnt);
    assign w_parent = (r_pos - AW'(1)) >> 1;

    always_comb begin
        n_state    = r_state;
        n_cmd      = r_cmd;
        n_val      = r_val;
        n_cnt      = r_cnt;
        n_pos      = r_pos;
        n_cur      = r_cur;
        n_res      = r_res;
        n_best     = r_best;
        n_best_idx = r_best_idx;
        n_idx      = r_idx;
        n_pend     = r_pend;
        n_hit      = r_hit;
        fin        = 1'b0;
        fin_status = ST_OK;
        fin_value  = '0;
        ram_we     = 1'b0;
        ram_waddr  = r_pos;
        ram_wdata  = r_cur;
        ram_raddr  = '0;
        cmp_a      = r_cur;
        cmp_b      = ram_rdata;

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_cmd = i_command;
                    n_val = i_value;
                    unique case (i_command)
                        CMD_INSERT: begin
                            if (r_cnt == CW'(CAPACITY)) begin
                                fin        = 1'b1;
                                fin_status = ST_FULL;
                            end else begin
                                n_pos   = r_cnt[AW-1:0];
                                n_cur   = i_value;
                                n_state = S_UP_RD;
                            end
                        end
                        CMD_REMOVE, CMD_PEEK: begin
                            if (r_cnt == '0) begin
                                fin        = 1'b1;
                                fin_status = ST_EMPTY;
                            end else begin
                                ram_raddr = '0;
                                n_state   = (i_command == CMD_PEEK) ? S_PEEK : S_RM_ROOT;
                            end
                        end
                        CMD_SEARCH: begin
                            n_idx   = '0;
                            n_pend  = 1'b0;
                            n_hit   = 1'b0;
                            n_state = S_SCAN;
                        end
                        CMD_MAX: begin
                            if (r_cnt == '0) begin
                                fin        = 1'b1;
                                fin_status = ST_EMPTY;
                            end else begin
                                n_idx   = '0;
                                n_pend  = 1'b0;
                                n_best  = DATA_MIN;
                                n_state = S_SCAN;
                            end
                        end
                        default: begin
                            fin = 1'b1;
                        end
                    endcase
                end
            end

            // Climb: move the parent down into the hole while the new value is smaller.
            S_UP_RD: begin
                if (r_pos == '0) begin
                    ram_we  = 1'b1;
                    n_cnt   = r_cnt + CW'(1);
                    fin     = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    ram_raddr = w_parent;
                    n_state   = S_UP_CMP;
                end
            end

            S_UP_CMP: begin
                cmp_a = r_cur;
                cmp_b = ram_rdata;
                ram_we = 1'b1;
                if (cmp.lt) begin
                    ram_wdata = ram_rdata;
                    n_pos     = w_parent;
                    n_state   = S_UP_RD;
                end else begin
                    n_cnt   = r_cnt + CW'(1);
                    fin     = 1'b1;
                    n_state = S_IDLE;
                end
            end

            S_RM_ROOT: begin
                n_res     = ram_rdata;
                ram_raddr = AW'(r_cnt - CW'(1));
                n_state   = S_RM_LAST;
            end

            S_RM_LAST: begin
                n_cur   = ram_rdata;
                n_cnt   = r_cnt - CW'(1);
                n_pos   = '0;
                n_state = S_DN_L;
            end

            // Descend: fetch left child, then right child if present.
            S_DN_L: begin
                if (w_lc >= w_cnt_x) begin
                    ram_we     = 1'b1;
                    fin        = 1'b1;
                    fin_value  = r_res;
                    n_state    = S_IDLE;
                end else begin
                    ram_raddr = w_lc[AW-1:0];
                    n_state   = S_DN_R;
                end
            end

            S_DN_R: begin
                n_best     = ram_rdata;
                n_best_idx = w_lc[AW-1:0];
                if (w_rc < w_cnt_x) begin
                    ram_raddr = w_rc[AW-1:0];
                    n_state   = S_DN_C;
                end else begin
                    n_state = S_DN_D;
                end
            end

            // Left child wins ties.
            S_DN_C: begin
                cmp_a = ram_rdata;
                cmp_b = r_best;
                if (cmp.lt) begin
                    n_best     = ram_rdata;
                    n_best_idx = w_rc[AW-1:0];
                end
                n_state = S_DN_D;
            end

            S_DN_D: begin
                cmp_a  = r_best;
                cmp_b  = r_cur;
                ram_we = 1'b1;
                if (cmp.lt) begin
                    ram_wdata = r_best;
                    n_pos     = r_best_idx;
                    n_state   = S_DN_L;
                end else begin
                    fin       = 1'b1;
                    fin_value = r_res;
                    n_state   = S_IDLE;
                end
            end

            S_PEEK: begin
                fin       = 1'b1;
                fin_value = ram_rdata;
                n_state   = S_IDLE;
            end

            // One entry read per cycle; data of the previous read is checked here.
            S_SCAN: begin
                cmp_a = ram_rdata;
                cmp_b = (r_cmd == CMD_SEARCH) ? r_val : r_best;
                if (r_pend) begin
                    if (r_cmd == CMD_SEARCH) begin
                        n_hit = r_hit | cmp.eq;
                    end else if (cmp.gt) begin
                        n_best = ram_rdata;
                    end
                end
                if (r_idx < r_cnt) begin
                    ram_raddr = r_idx[AW-1:0];
                    n_idx     = r_idx + CW'(1);
                    n_pend    = 1'b1;
                end else begin
                    n_pend  = 1'b0;
                    fin     = 1'b1;
                    n_state = S_IDLE;
                    if (r_cmd == CMD_SEARCH) begin
                        fin_status = n_hit ? ST_OK : ST_NOTFOUND;
                        fin_value  = n_hit ? r_val : '0;
                    end else begin
                        fin_value = n_best;
                    end
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_pend  <= 1'b0;
            r_hit   <= 1'b0;
            o_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_pend  <= n_pend;
            r_hit   <= n_hit;
            o_done  <= fin;
        end
        r_cmd      <= n_cmd;
        r_val      <= n_val;
        r_pos      <= n_pos;
        r_cur      <= n_cur;
        r_res      <= n_res;
        r_best     <= n_best;
        r_best_idx <= n_best_idx;
        r_idx      <= n_idx;
        if (fin) begin
            o_status       <= fin_status;
            o_result_value <= fin_value;
            o_entry_count  <= 5'(n_cnt);
        end
    end

`include "min_heap_priority_queue_assert.svh"

    `MHPQ_ASSERT_NOW(a_done_idle, o_done, !busy, "result issued while sequencer busy")
    `MHPQ_ASSERT_NEXT(a_accept_busy, start && !busy && !fin, busy,
        "accepted transaction did not start work")
    `MHPQ_ASSERT_NOW(a_cnt_bound, 1'b1, r_cnt <= CW'(CAPACITY), "fill count above capacity")
    `MHPQ_ASSERT_NOW(a_full_count, o_done && o_status == ST_FULL, r_cnt == CW'(CAPACITY),
        "full reported with room left")

endmodule

`default_nettype wire

@@ rtl/mhpq_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

module mhpq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

@@ rtl/mhpq_cmp.sv @@
`timescale 1ns / 1ps
`default_nettype none

module mhpq_cmp (
    input  wire logic signed [mhpq_pkg::DATA_W-1:0] i_a,
    input  wire logic signed [mhpq_pkg::DATA_W-1:0] i_b,
    output mhpq_pkg::t_cmp_flags                    o_flags
);

    import mhpq_pkg::*;

    always_comb begin
        o_flags.lt = (i_a < i_b);
        o_flags.eq = (i_a == i_b);
        o_flags.gt = (i_a > i_b);
    end

endmodule

`default_nettype wire
